[design/rcp_pkg.sv]
// ----------------------------------------------------------------------------
// rcp_pkg
// Types, constants and helpers shared by the chunk header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rcp_pkg;

  // chunk format codes
  localparam logic [1:0] FMT_FULL     = 2'd0;
  localparam logic [1:0] FMT_NO_SID   = 2'd1;
  localparam logic [1:0] FMT_TS_ONLY  = 2'd2;
  localparam logic [1:0] FMT_NONE     = 2'd3;

  // basic header forms
  localparam logic [1:0] FORM_ONE     = 2'd0;
  localparam logic [1:0] FORM_TWO     = 2'd1;
  localparam logic [1:0] FORM_THREE   = 2'd2;

  localparam logic [5:0]  CSID_SEL_TWO   = 6'd0;
  localparam logic [5:0]  CSID_SEL_THREE = 6'd1;
  localparam logic [16:0] CSID_OFFSET    = 17'd64;
  localparam logic [23:0] TS_ESCAPE      = 24'hffffff;
  localparam logic [4:0]  EXT_TS_BYTES   = 5'd4;

  localparam int unsigned RESULT_BITS = 123;
  localparam int unsigned TDATA_BITS  = 128;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       restart;
  } rcp_item_t;

  typedef struct packed {
    logic [4:0]  header_bytes;
    logic [31:0] message_stream_id;
    logic [7:0]  message_type;
    logic [23:0] message_length;
    logic        ext_timestamp_used;
    logic [31:0] timestamp_value;
    logic [1:0]  csid_form;
    logic [16:0] chunk_stream_id;
    logic [1:0]  fmt_code;
  } rcp_result_t;

  typedef struct packed {
    logic [4:0]  byte_position;
    logic [1:0]  held_fmt;
    logic [1:0]  held_form;
    logic [16:0] csid_accum;
    logic [31:0] timestamp_accum;
    logic [23:0] length_accum;
    logic [7:0]  type_hold;
    logic [31:0] streamid_accum;
    logic        ext_pending;
    logic        last_ext_flag;
  } rcp_state_t;

  // message header length for each format
  function automatic logic [4:0] msg_len_of_fmt(input logic [1:0] fmt);
    logic [4:0] len;
    case (fmt)
      FMT_FULL:    len = 5'd11;
      FMT_NO_SID:  len = 5'd7;
      FMT_TS_ONLY: len = 5'd3;
      default:     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[design/rcp_in_stage.sv]
// ----------------------------------------------------------------------------
// rcp_in_stage
// Input register of the parser: holds one header byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rcp_pkg::rcp_item_t in_item_i,
  input  wire logic              advance_i,
  output logic                   held_valid_o,
  output rcp_pkg::rcp_item_t     held_item_o
);

  logic               valid_d, valid_q;
  rcp_pkg::rcp_item_t item_q;
  logic               accept;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

`default_nettype wire

[design/rcp_parser.sv]
// ----------------------------------------------------------------------------
// rcp_parser
// Header state registers and the per-byte update; flags a completed header.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire rcp_pkg::rcp_item_t item_i,
  output logic                    done_o,
  output rcp_pkg::rcp_result_t    result_o
);

  rcp_pkg::rcp_state_t st_q, st_d;

  logic [4:0] p;
  logic [4:0] basic_len;
  logic [4:0] msg_end;
  logic [4:0] q;
  logic [4:0] r;
  logic [4:0] total;
  logic [5:0] p_inc;
  logic [7:0] b;
  logic [1:0] fmt;
  logic [1:0] form;
  logic [16:0] csid;
  logic [31:0] ts;
  logic [23:0] len;
  logic [7:0]  typ;
  logic [31:0] sid;
  logic        ext;
  logic [23:0] ts_shift;

  always_comb begin
    b     = item_i.stream_byte;
    p     = item_i.restart ? 5'd0 : st_q.byte_position;
    fmt   = st_q.held_fmt;
    form  = st_q.held_form;
    csid  = st_q.csid_accum;
    ts    = st_q.timestamp_accum;
    len   = st_q.length_accum;
    typ   = st_q.type_hold;
    sid   = st_q.streamid_accum;
    ext   = st_q.ext_pending;

    // first byte: basic header
    if (p == 5'd0) begin
      fmt = b[7:6];
      if (b[5:0] == rcp_pkg::CSID_SEL_TWO) begin
        form = rcp_pkg::FORM_TWO;
        csid = rcp_pkg::CSID_OFFSET;
      end else if (b[5:0] == rcp_pkg::CSID_SEL_THREE) begin
        form = rcp_pkg::FORM_THREE;
        csid = rcp_pkg::CSID_OFFSET;
      end else begin
        form = rcp_pkg::FORM_ONE;
        csid = {11'd0, b[5:0]};
      end
      ts  = '0;
      len = '0;
      typ = '0;
      sid = '0;
      ext = (fmt == rcp_pkg::FMT_NONE) ? st_q.last_ext_flag : 1'b0;
    end

    basic_len = {3'd0, form} + 5'd1;
    msg_end   = basic_len + rcp_pkg::msg_len_of_fmt(fmt);
    q         = p - basic_len;
    r         = p - msg_end;
    ts_shift  = {ts[15:0], b};

    if (p != 5'd0 && p < basic_len) begin
      if (p == 5'd1) begin
        csid = rcp_pkg::CSID_OFFSET + {9'd0, b};
      end else begin
        csid = csid + {1'b0, b, 8'd0};
      end
    end else if (p >= basic_len && p < msg_end) begin
      if (q < 5'd3) begin
        ts = {8'd0, ts_shift};
        if (q == 5'd2) begin
          ext = (ts_shift == rcp_pkg::TS_ESCAPE);
        end
      end else if (q < 5'd6) begin
        len = {len[15:0], b};
      end else if (q == 5'd6) begin
        typ = b;
      end else begin
        // stream id arrives little endian
        case (q)
          5'd7:    sid = sid | {24'd0, b};
          5'd8:    sid = sid | {16'd0, b, 8'd0};
          5'd9:    sid = sid | {8'd0, b, 16'd0};
          5'd10:   sid = sid | {b, 24'd0};
          default: sid = sid;
        endcase
      end
    end else if (p >= msg_end) begin
      // extended timestamp, big endian
      if (r == 5'd0) begin
        ts = {24'd0, b};
      end else begin
        ts = {ts[23:0], b};
      end
    end

    total  = msg_end + (ext ? rcp_pkg::EXT_TS_BYTES : 5'd0);
    p_inc  = {1'b0, p} + 6'd1;
    done_o = (p_inc >= {1'b0, total});

    result_o.fmt_code           = fmt;
    result_o.chunk_stream_id    = csid;
    result_o.csid_form          = form;
    result_o.timestamp_value    = ts;
    result_o.ext_timestamp_used = ext;
    result_o.message_length     = len;
    result_o.message_type       = typ;
    result_o.message_stream_id  = sid;
    result_o.header_bytes       = p_inc[4:0];

    st_d.held_fmt        = fmt;
    st_d.held_form       = form;
    st_d.csid_accum      = csid;
    st_d.timestamp_accum = ts;
    st_d.length_accum    = len;
    st_d.type_hold       = typ;
    st_d.streamid_accum  = sid;
    st_d.ext_pending     = ext;
    st_d.last_ext_flag   = st_q.last_ext_flag;
    if (done_o) begin
      st_d.byte_position = 5'd0;
      if (fmt != rcp_pkg::FMT_NONE) begin
        st_d.last_ext_flag = ext;
      end
    end else begin
      st_d.byte_position = p_inc[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

[design/rtmp_chunk_header_parser.sv]
// ----------------------------------------------------------------------------
// rtmp_chunk_header_parser
// Byte-wide chunk header parser with one result per completed header.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle and, on the last byte of each chunk header
// (1 to 18 bytes), presents one result with the decoded format, chunk stream
// id, timestamp, message fields and header length. A byte goes through an
// input register and the parser's combinational update into a result register,
// which is loaded as a header's last byte leaves the input register. The input
// register and the result register decouple the two sides: bytes keep flowing
// at one per cycle while a result is waiting, and only a header completing
// while the previous result is still untaken stalls the input. Driving tuser
// high with a byte discards any partial header and starts a new one there.
`default_nettype none

module rtmp_chunk_header_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] stream_byte
  input  wire logic         s_axis_tuser_i,   // [0] restart
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [1:0] fmt_code, [18:2] chunk_stream_id, [20:19] csid_form,
  // [52:21] timestamp_value, [53] ext_timestamp_used, [77:54] message_length,
  // [85:78] message_type, [117:86] message_stream_id, [122:118] header_bytes,
  // [127:123] zero
  output logic [127:0]      m_axis_tdata_o
);

  rcp_pkg::rcp_item_t   in_item;
  rcp_pkg::rcp_item_t   held_item;
  rcp_pkg::rcp_result_t result;
  rcp_pkg::rcp_result_t res_q;
  logic                 held_valid;
  logic                 advance;
  logic                 done;
  logic                 res_valid_d, res_valid_q;

  assign in_item.stream_byte = s_axis_tdata_i;
  assign in_item.restart     = s_axis_tuser_i;

  // only a byte that finishes a header needs the result slot free or being emptied
  assign advance = held_valid && (!done || !res_valid_q || m_axis_tready_i);

  rcp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  rcp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (held_item),
    .done_o   (done),
    .result_o (result)
  );

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance && done) begin
      res_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && done) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = {(rcp_pkg::TDATA_BITS - rcp_pkg::RESULT_BITS)'(0), res_q};

endmodule

`default_nettype wire
